@@ rtl/gpm_pkg.sv @@
package gpm_pkg;

  // pattern capacity and derived widths
  localparam int MAX_PATTERN = 32;
  localparam int NCELL       = MAX_PATTERN + 1;
  localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

  // operation codes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_SUBJECT = 2'd2;
  localparam logic [1:0] OP_END     = 2'd3;

  // pattern syntax characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_OPEN   = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CLOSE  = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  // role that a stored pattern byte plays
  typedef enum logic [3:0] {
    R_SKIP, R_STAR, R_ANY, R_LIT, R_ESC, R_OPEN, R_M1, R_MESC, R_MRANGE
  } role_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] lead;
    logic             fresh;
    logic             ic;
    logic             step;
    logic             wr;
    logic [7:0]       wbyte;
    role_t            wrole;
    logic [LEN_W-1:0] wowner;
    logic [LEN_W-1:0] cur_owner;
    logic             range_fix;
    logic             set_neg;
    logic [7:0]       subj;
  } gpm_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
    return r;
  endfunction

  // folded byte inside the range spanned by x and y
  function automatic logic in_span(input logic [7:0] b, input logic [7:0] x,
                                   input logic [7:0] y, input logic ic);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] fb;
    lo = (x < y) ? x : y;
    hi = (x < y) ? y : x;
    lo = fold(lo, ic);
    hi = fold(hi, ic);
    fb = fold(b, ic);
    return (fb >= lo) && (fb <= hi);
  endfunction

endpackage

@@ rtl/gpm_if.sv @@
interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  modport source (output valid, output operation, output byte_value, input ready);
  modport sink (input valid, input operation, input byte_value, output ready);
endinterface

interface gpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

interface gpm_cfg_if;
  logic valid;
  logic ready;
  logic ignore_case;
  modport source (output valid, output ignore_case, input ready);
  modport sink (input valid, input ignore_case, output ready);
endinterface

@@ rtl/gpm_cell.sv @@
module gpm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gpm_pkg::LEN_W-1:0] idx,
  input  gpm_pkg::gpm_ctl_t         ctl,
  input  logic [7:0]                nb1,
  input  logic [7:0]                nb2,
  input  logic                      class_any,
  input  logic                      land_in,
  output logic                      land_out,
  output logic [7:0]                byte_o,
  output logic                      mhit_o,
  output logic [gpm_pkg::LEN_W-1:0] owner_o,
  output logic                      act_o
);
  import gpm_pkg::*;

  logic [7:0]       byte_r;
  role_t            role_r;
  logic [LEN_W-1:0] owner_r;
  logic             neg_r;
  logic             act_r;

  logic [LEN_W:0] idx_x;
  logic [LEN_W:0] len_x;
  logic           in_pat;
  logic           at_end;
  logic           old;
  logic           start;
  logic           star;
  logic           hit;
  logic [7:0]     esc_v;
  logic           act_new;

  assign idx_x  = {1'b0, idx};
  assign len_x  = {1'b0, ctl.len};
  assign in_pat = idx_x < len_x;
  assign at_end = idx == ctl.len;
  assign old    = ctl.fresh ? (idx <= ctl.lead) : act_r;
  assign esc_v  = (idx_x + 1'b1 < len_x) ? nb1 : CH_BSLASH;
  assign star   = role_r == R_STAR;
  assign start  = (role_r == R_STAR) || (role_r == R_ANY) || (role_r == R_LIT) ||
                  (role_r == R_ESC) || (role_r == R_OPEN);

  // element hit for the current subject byte
  always_comb begin
    unique case (role_r)
      R_ANY:   hit = 1'b1;
      R_LIT:   hit = in_span(ctl.subj, byte_r, byte_r, ctl.ic);
      R_ESC:   hit = in_span(ctl.subj, esc_v, esc_v, ctl.ic);
      R_OPEN:  hit = neg_r ^ class_any;
      default: hit = 1'b0;
    endcase
  end

  // class member hit, ORed per class by the top level
  always_comb begin
    unique case (role_r)
      R_M1:     mhit_o = in_pat && in_span(ctl.subj, byte_r, byte_r, ctl.ic);
      R_MESC:   mhit_o = in_pat && in_span(ctl.subj, esc_v, esc_v, ctl.ic);
      R_MRANGE: mhit_o = in_pat && in_span(ctl.subj, byte_r, nb2, ctl.ic);
      default:  mhit_o = 1'b0;
    endcase
  end

  // token passed along the row of cells
  always_comb begin
    act_new  = 1'b0;
    land_out = 1'b0;
    if (in_pat && start) begin
      act_new  = land_in | (star & old);
      land_out = star ? act_new : (old & hit);
    end else if (in_pat) begin
      land_out = land_in;
    end else if (at_end) begin
      act_new = land_in;
    end
  end

  // active bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (ctl.step) begin
      act_r <= act_new;
    end
  end

  // pattern byte, its role, owner and negation flag
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (at_end) begin
        byte_r  <= ctl.wbyte;
        role_r  <= ctl.wrole;
        owner_r <= ctl.wowner;
        neg_r   <= 1'b0;
      end
      if (ctl.range_fix && (idx_x + 2'd2 == len_x)) role_r <= R_MRANGE;
      if (ctl.range_fix && (idx_x + 1'b1 == len_x)) role_r <= R_SKIP;
      if (ctl.set_neg && idx == ctl.cur_owner) neg_r <= 1'b1;
    end
  end

  assign byte_o  = byte_r;
  assign owner_o = owner_r;
  assign act_o   = old;

endmodule

@@ rtl/gpm_ctrl.sv @@
module gpm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_byte,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_matched,
  output logic              out_ovf,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              act_at_len,
  output gpm_pkg::gpm_ctl_t ctl
);
  import gpm_pkg::*;

  typedef enum logic [2:0] {C_OUT, C_OESC, C_IFIRST, C_IN, C_IESC, C_IM, C_IMD} ctx_t;

  ctx_t             ctx_r, ctx_nxt;
  logic [LEN_W-1:0] len_r, lead_r, own_r, own_nxt;
  logic             ovf_r, fresh_r, ic_r;
  logic             ov_r, om_r, oo_r;
  logic             acc, full, wr;
  role_t            wrole;
  logic [LEN_W-1:0] wowner;
  logic             set_neg, range_fix;

  assign in_ready = !ov_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign full     = len_r == LEN_W'(MAX_PATTERN);
  assign wr       = acc && (in_op == OP_APPEND) && !full;

  // incremental parse of the appended byte
  always_comb begin
    wrole     = R_SKIP;
    wowner    = own_r;
    own_nxt   = own_r;
    ctx_nxt   = ctx_r;
    set_neg   = 1'b0;
    range_fix = 1'b0;
    unique case (ctx_r)
      C_OUT: begin
        if (in_byte == CH_STAR) begin
          wrole = R_STAR;
        end else if (in_byte == CH_QUEST) begin
          wrole = R_ANY;
        end else if (in_byte == CH_OPEN) begin
          wrole   = R_OPEN;
          wowner  = len_r;
          own_nxt = len_r;
          ctx_nxt = C_IFIRST;
        end else if (in_byte == CH_BSLASH) begin
          wrole   = R_ESC;
          ctx_nxt = C_OESC;
        end else begin
          wrole = R_LIT;
        end
      end
      C_OESC: ctx_nxt = C_OUT;
      C_IESC: ctx_nxt = C_IN;
      C_IMD: begin
        range_fix = 1'b1;
        ctx_nxt   = C_IN;
      end
      C_IFIRST, C_IN, C_IM: begin
        if (ctx_r == C_IFIRST && in_byte == CH_CARET) begin
          set_neg = 1'b1;
          ctx_nxt = C_IN;
        end else if (ctx_r == C_IM && in_byte == CH_DASH) begin
          wrole   = R_M1;
          ctx_nxt = C_IMD;
        end else if (in_byte == CH_BSLASH) begin
          wrole   = R_MESC;
          ctx_nxt = C_IESC;
        end else if (in_byte == CH_CLOSE) begin
          ctx_nxt = C_OUT;
        end else begin
          wrole   = R_M1;
          ctx_nxt = C_IM;
        end
      end
      default: ctx_nxt = C_OUT;
    endcase
  end

  // pattern bookkeeping, case mode and result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r   <= C_OUT;
      len_r   <= '0;
      lead_r  <= '0;
      own_r   <= '0;
      ovf_r   <= 1'b0;
      fresh_r <= 1'b1;
      ic_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid) ic_r <= cfg_data;
      if (out_ready) ov_r <= 1'b0;
      if (acc) begin
        unique case (in_op)
          OP_CLEAR: begin
            ctx_r   <= C_OUT;
            len_r   <= '0;
            lead_r  <= '0;
            ovf_r   <= 1'b0;
            fresh_r <= 1'b1;
          end
          OP_APPEND: begin
            fresh_r <= 1'b1;
            if (full) begin
              ovf_r <= 1'b1;
            end else begin
              ctx_r <= ctx_nxt;
              own_r <= own_nxt;
              len_r <= len_r + 1'b1;
              if (lead_r == len_r && ctx_r == C_OUT && in_byte == CH_STAR)
                lead_r <= lead_r + 1'b1;
            end
          end
          OP_SUBJECT: fresh_r <= 1'b0;
          OP_END: begin
            ov_r    <= 1'b1;
            om_r    <= !ovf_r && act_at_len;
            oo_r    <= ovf_r;
            fresh_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid   = ov_r;
  assign out_matched = om_r;
  assign out_ovf     = oo_r;

  assign ctl.len       = len_r;
  assign ctl.lead      = lead_r;
  assign ctl.fresh     = fresh_r;
  assign ctl.ic        = ic_r;
  assign ctl.step      = acc && (in_op == OP_SUBJECT);
  assign ctl.wr        = wr;
  assign ctl.wbyte     = in_byte;
  assign ctl.wrole     = wrole;
  assign ctl.wowner    = wowner;
  assign ctl.cur_owner = own_r;
  assign ctl.range_fix = range_fix;
  assign ctl.set_neg   = set_neg;
  assign ctl.subj      = in_byte;

endmodule

@@ rtl/glob_pattern_matcher.sv @@
// channel | dir | word                                | accepted when
// in_ch   | in  | operation[1:0], byte_value[7:0]     | valid && ready
// out_ch  | out | matched, pattern_overflow           | valid && ready
// cfg_ch  | in  | ignore_case                         | valid && ready (always ready)
//
// One input word per cycle for every operation while in_ch.ready is high; end of
// subject gives its result word in the following cycle from an output register.
// A subject byte ripples a token combinationally through the row of pattern cells;
// that chain plus the per-class member OR sets the clock period.
// Input stalls only while a result word waits and out_ch.ready is low.
// Synchronous active-low reset empties the pattern and clears case folding.
module glob_pattern_matcher (
  input logic      clk,
  input logic      rst_n,
  gpm_in_if.sink   in_ch,
  gpm_out_if.source out_ch,
  gpm_cfg_if.sink  cfg_ch
);
  import gpm_pkg::*;

  gpm_ctl_t         ctl;
  logic [7:0]       bytes  [NCELL];
  logic [LEN_W-1:0] owners [NCELL];
  logic             mhit   [NCELL];
  logic             cany   [NCELL];
  logic             land   [NCELL+1];
  logic [NCELL-1:0] act;

  assign cfg_ch.ready = 1'b1;
  assign land[0]      = 1'b0;

  gpm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_op       (in_ch.operation),
    .in_byte     (in_ch.byte_value),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_matched (out_ch.matched),
    .out_ovf     (out_ch.pattern_overflow),
    .cfg_valid   (cfg_ch.valid),
    .cfg_data    (cfg_ch.ignore_case),
    .act_at_len  (act[ctl.len]),
    .ctl         (ctl)
  );

  for (genvar p = 0; p < NCELL; p++) begin : g_cell
    logic [7:0] nb1;
    logic [7:0] nb2;

    // neighbor bytes for escapes and range ends
    if (p + 1 < NCELL) begin : g_n1
      assign nb1 = bytes[p+1];
    end else begin : g_n1z
      assign nb1 = '0;
    end
    if (p + 2 < NCELL) begin : g_n2
      assign nb2 = bytes[p+2];
    end else begin : g_n2z
      assign nb2 = '0;
    end

    // members of the class opened at this position
    always_comb begin
      cany[p] = 1'b0;
      for (int q = 0; q < NCELL; q++) begin
        if (mhit[q] && owners[q] == LEN_W'(p)) cany[p] = 1'b1;
      end
    end

    gpm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (LEN_W'(p)),
      .ctl       (ctl),
      .nb1       (nb1),
      .nb2       (nb2),
      .class_any (cany[p]),
      .land_in   (land[p]),
      .land_out  (land[p+1]),
      .byte_o    (bytes[p]),
      .mhit_o    (mhit[p]),
      .owner_o   (owners[p]),
      .act_o     (act[p])
    );
  end

endmodule
